FILE: src/gpns_pkg.sv
`timescale 1ns / 1ps

package gpns_pkg;

  localparam int COORD_W    = 20;
  localparam int SKIP_W     = 16;
  localparam int LA_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_SMOOTH = 3;

  localparam int MAG_W  = COORD_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int LIM_W  = 2 * SKIP_W;

  localparam logic [SKIP_W-1:0] SKIP_RST = 16'd320;
  localparam logic [LA_W-1:0]   LA_RST   = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIP = 1'b0,
    CFG_LA   = 1'b1
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } node_t;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_RDE  = 6'b000010,
    ST_EMIT = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_SQ   = 6'b010000,
    ST_CMP  = 6'b100000
  } state_t;

  typedef struct packed {
    logic store;
    logic start;
    logic emit;
    logic addr_j;
    logic advance;
    logic take_best;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_last;
    logic short_path;
    logic scan_ok;
    logic less;
  } sts_t;

  function automatic logic [MAG_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic [MAG_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[MAG_W-1] ? MAG_W'(~d + 1'b1) : d;
  endfunction

  function automatic logic [SQ_W-1:0] square(input logic [MAG_W-1:0] a);
    return SQ_W'(a) * SQ_W'(a);
  endfunction

endpackage

FILE: src/gpns_channels.sv
`timescale 1ns / 1ps

interface gpns_node_if;
  logic                   valid;
  logic                   ready;
  gpns_pkg::coord_t       pos_x;
  gpns_pkg::coord_t       pos_y;
  gpns_pkg::coord_t       pos_z;
  logic                   last_in;

  modport source (output valid, pos_x, pos_y, pos_z, last_in, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_in, output ready);
endinterface

interface gpns_res_if;
  logic                   valid;
  logic                   ready;
  gpns_pkg::coord_t       out_x;
  gpns_pkg::coord_t       out_y;
  gpns_pkg::coord_t       out_z;
  logic                   smoothed;
  logic                   overflow;
  logic                   last_out;

  modport source (output valid, out_x, out_y, out_z, smoothed, overflow, last_out,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, smoothed, overflow, last_out,
                  output ready);
endinterface

FILE: src/gpns_ctrl.sv
`timescale 1ns / 1ps

module gpns_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  input  gpns_pkg::sts_t sts,
  output logic           in_ready,
  output gpns_pkg::cmd_t cmd
);

  gpns_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpns_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      gpns_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            cmd.start  = 1'b1;
            state_next = gpns_pkg::ST_RDE;
          end
        end
      end
      gpns_pkg::ST_RDE: begin
        state_next = gpns_pkg::ST_EMIT;
      end
      gpns_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          priority if (sts.is_last) begin
            cmd.clear  = 1'b1;
            state_next = gpns_pkg::ST_LOAD;
          end else if (sts.short_path) begin
            state_next = gpns_pkg::ST_RDE;
          end else begin
            state_next = gpns_pkg::ST_SCAN;
          end
        end
      end
      gpns_pkg::ST_SCAN: begin
        if (sts.scan_ok) begin
          cmd.addr_j = 1'b1;
          state_next = gpns_pkg::ST_SQ;
        end else begin
          cmd.take_best = 1'b1;
          state_next    = gpns_pkg::ST_RDE;
        end
      end
      gpns_pkg::ST_SQ: begin
        state_next = gpns_pkg::ST_CMP;
      end
      gpns_pkg::ST_CMP: begin
        if (sts.less) begin
          cmd.advance = 1'b1;
          state_next  = gpns_pkg::ST_SCAN;
        end else begin
          cmd.take_best = 1'b1;
          state_next    = gpns_pkg::ST_RDE;
        end
      end
      default: begin
        state_next = gpns_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: src/gpns_dp.sv
`timescale 1ns / 1ps

module gpns_dp #(
  parameter int MAX_NODES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gpns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpns_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gpns_pkg::node_t                     in_node,
  input  gpns_pkg::cmd_t                      cmd,
  output gpns_pkg::sts_t                      sts,
  output gpns_pkg::node_t                     out_node,
  output logic                                out_smoothed,
  output logic                                out_overflow,
  output logic                                out_last,
  output logic                                out_valid,
  input  logic                                out_ready
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int SW = ((CW > gpns_pkg::LA_W) ? CW : gpns_pkg::LA_W) + 1;

  gpns_pkg::node_t                   mem [MAX_NODES];
  gpns_pkg::node_t                   rd_data;
  gpns_pkg::node_t                   cur;
  logic [AW-1:0]                     rd_addr;
  logic [CW-1:0]                     count;
  logic                              ovf;
  logic [CW-1:0]                     e_idx;
  logic [CW-1:0]                     i_idx;
  logic [CW-1:0]                     j_idx;
  logic [CW-1:0]                     best_idx;
  logic [gpns_pkg::SKIP_W-1:0]       skip;
  logic [gpns_pkg::LA_W-1:0]         la;
  logic [gpns_pkg::LIM_W-1:0]        lim;
  logic [gpns_pkg::SQ_W-1:0]         sq_x;
  logic [gpns_pkg::SQ_W-1:0]         sq_y;
  logic [gpns_pkg::SQ_W-1:0]         sq_z;
  logic [gpns_pkg::DIST_W-1:0]       dist_sum;
  logic                              has_room;

  assign has_room = count < CW'(MAX_NODES);
  assign rd_addr  = cmd.addr_j ? j_idx[AW-1:0] : e_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.store && has_room) begin
      mem[count[AW-1:0]] <= in_node;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= gpns_pkg::SKIP_RST;
      la   <= gpns_pkg::LA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpns_pkg::CFG_SKIP: skip <= cfg_data[gpns_pkg::SKIP_W-1:0];
        gpns_pkg::CFG_LA:   la   <= cfg_data[gpns_pkg::LA_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim <= gpns_pkg::LIM_W'(skip) * gpns_pkg::LIM_W'(skip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.store) begin
      if (has_room) begin
        count <= count + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.start) begin
      e_idx <= '0;
    end else if (cmd.emit) begin
      e_idx <= e_idx + CW'(1);
    end else if (cmd.take_best) begin
      e_idx <= best_idx;
    end
    if (cmd.emit) begin
      cur      <= rd_data;
      i_idx    <= e_idx;
      best_idx <= e_idx + CW'(1);
      j_idx    <= e_idx + CW'(2);
    end else if (cmd.advance) begin
      best_idx <= j_idx;
      j_idx    <= j_idx + CW'(1);
    end
  end

  // squared distance of the candidate from the current node
  always_ff @(posedge clk) begin
    sq_x <= gpns_pkg::square(gpns_pkg::abs_diff(cur.x, rd_data.x));
    sq_y <= gpns_pkg::square(gpns_pkg::abs_diff(cur.y, rd_data.y));
    sq_z <= gpns_pkg::square(gpns_pkg::abs_diff(cur.z, rd_data.z));
  end

  assign dist_sum = gpns_pkg::DIST_W'(sq_x) + gpns_pkg::DIST_W'(sq_y) +
                    gpns_pkg::DIST_W'(sq_z);

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.is_last    = ((CW + 1)'(e_idx) + (CW + 1)'(1)) == (CW + 1)'(count);
  assign sts.short_path = (CW + 1)'(count) < (CW + 1)'(gpns_pkg::MIN_SMOOTH);
  assign sts.scan_ok    = (j_idx < count) && (SW'(j_idx) <= SW'(i_idx) + SW'(la));
  assign sts.less       = dist_sum < gpns_pkg::DIST_W'(lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_node     <= rd_data;
      out_smoothed <= !sts.short_path && (e_idx != '0);
      out_overflow <= ovf;
      out_last     <= sts.is_last;
    end
  end

endmodule

FILE: src/greedy_path_node_simplifier_top.sv
`timescale 1ns / 1ps

// Collects a path of 3D nodes (signed, 1/16 units) one node per cycle until a node with
// last_in set, storing up to MAX_NODES in an on-chip memory; later nodes are dropped and
// every result of that path carries overflow. A path under three nodes comes out as is;
// otherwise the first node comes out, then from each kept node the block scans ahead up to
// lookahead nodes and keeps the furthest one reached before a candidate at or beyond skip_distance
// (at least the next node), marked smoothed; no node is taken while a path is emitted.
// Emission is set by the single memory read port and the distance unit: each kept node
// is read (RDE) and emitted (EMIT); each candidate scanned takes one read, one squaring
// stage and one compare (SCAN, SQ, CMP); a scan that stops at the lookahead limit or the
// path end instead of on a failed compare takes one more scan step (the kept node that
// ends the path is not scanned from), and the result register may wait on ready.
module greedy_path_node_simplifier_top #(
  parameter int MAX_NODES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gpns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gpns_pkg::CFG_DATA_W-1:0]   cfg_data,
  gpns_node_if.sink                         node,
  gpns_res_if.source                        result
);

  gpns_pkg::cmd_t  cmd;
  gpns_pkg::sts_t  sts;
  gpns_pkg::node_t in_node;
  gpns_pkg::node_t out_node;

  assign in_node.x = node.pos_x;
  assign in_node.y = node.pos_y;
  assign in_node.z = node.pos_z;

  gpns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (node.valid),
    .in_last  (node.last_in),
    .sts      (sts),
    .in_ready (node.ready),
    .cmd      (cmd)
  );

  gpns_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_node      (in_node),
    .cmd          (cmd),
    .sts          (sts),
    .out_node     (out_node),
    .out_smoothed (result.smoothed),
    .out_overflow (result.overflow),
    .out_last     (result.last_out),
    .out_valid    (result.valid),
    .out_ready    (result.ready)
  );

  assign result.out_x = out_node.x;
  assign result.out_y = out_node.y;
  assign result.out_z = out_node.z;

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result loaded while result register is occupied");

  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    node.valid && node.ready && node.last_in |=> !node.ready)
    else $error("input still taken after final node of path");

  a_last_reopens_load: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && sts.is_last |=> node.ready && result.valid && result.last_out)
    else $error("final result did not return block to loading");

endmodule

FILE: bench/tb_greedy_path_node_simplifier_top.sv
`timescale 1ns / 1ps

module tb_greedy_path_node_simplifier_top;

  localparam int PATH_CAP      = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int NUM_SETTINGS  = 10;
  localparam int PHASE_NODES   = 12;
  localparam int NUM_PROBES    = 23;

  localparam gpns_pkg::coord_t C_MAX = 20'sh7FFFF;
  localparam gpns_pkg::coord_t C_MIN = 20'sh80000;

  typedef struct packed {
    gpns_pkg::coord_t x;
    gpns_pkg::coord_t y;
    gpns_pkg::coord_t z;
    logic   smoothed;
    logic   overflow;
    logic   last;
  } kept_t;

  typedef struct packed {
    gpns_pkg::coord_t x;
    gpns_pkg::coord_t y;
    gpns_pkg::coord_t z;
    logic   last;
    logic   known;
    logic   want_sm;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [gpns_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gpns_pkg::CFG_DATA_W-1:0] cfg_data;

  gpns_node_if node_ch();
  gpns_res_if res_ch();

  greedy_path_node_simplifier_top #(
    .MAX_NODES(PATH_CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .node(node_ch),
    .result(res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow state of the block
  gpns_pkg::node_t   path_nodes [PATH_CAP];
  int                path_len;
  logic              path_truncated;
  logic [gpns_pkg::SKIP_W-1:0] skip_reg;
  logic [gpns_pkg::LA_W-1:0]   reach_reg;

  kept_t kept_q[$];
  bit    hold_req;
  int    mismatches;
  int    checked_total;
  int    nodes_sent;
  int    paths_sent;
  int    truncated_paths;
  int    cycles;

  // final result of each known row is the row's own node
  probe_row_t probes [NUM_PROBES] = '{
    '{C_MAX, C_MIN, 20'sd0, 1'b1, 1'b1, 1'b0},
    '{C_MIN, C_MAX, -20'sd1, 1'b1, 1'b1, 1'b0},
    '{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0},
    '{20'sd1, -20'sd2, 20'sd3, 1'b1, 1'b1, 1'b0},
    '{C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, 1'b0},
    '{C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, 1'b0},
    '{20'sd0, 20'sd0, 20'sd0, 1'b1, 1'b1, 1'b1},
    '{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0},
    '{20'sd100, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0},
    '{20'sd200, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0},
    '{20'sd300, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0},
    '{20'sd400, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0},
    '{20'sd500, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0},
    '{20'sd600, 20'sd0, 20'sd0, 1'b1, 1'b0, 1'b0},
    '{20'sd1000, 20'sd1000, 20'sd1000, 1'b0, 1'b0, 1'b0},
    '{20'sd1010, 20'sd1000, 20'sd1000, 1'b0, 1'b0, 1'b0},
    '{20'sd1319, 20'sd1000, 20'sd1000, 1'b0, 1'b0, 1'b0},
    '{20'sd1000, 20'sd1320, 20'sd1000, 1'b0, 1'b0, 1'b0},
    '{20'sd1319, 20'sd1000, 20'sd1192, 1'b1, 1'b0, 1'b0},
    '{-20'sd50, -20'sd50, -20'sd50, 1'b0, 1'b0, 1'b0},
    '{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0},
    '{20'sd134, 20'sd134, 20'sd134, 1'b0, 1'b0, 1'b0},
    '{20'sd135, 20'sd135, 20'sd135, 1'b1, 1'b0, 1'b0}
  };

  logic [gpns_pkg::SKIP_W-1:0] skip_plan [NUM_SETTINGS] =
    '{16'd320, 16'd0, 16'd65535, 16'd1, 16'd40000, 16'd65535, 16'd1500, 16'd800,
      16'd0, 16'd0};
  logic [gpns_pkg::LA_W-1:0] reach_plan [NUM_SETTINGS] =
    '{4'd5, 4'd5, 4'd15, 4'd1, 4'd0, 4'd2, 4'd8, 4'd12, 4'd0, 4'd0};

  function automatic longint sep2(input int a, input int b);
    longint dx, dy, dz;
    dx = longint'($signed(path_nodes[a].x)) - longint'($signed(path_nodes[b].x));
    dy = longint'($signed(path_nodes[a].y)) - longint'($signed(path_nodes[b].y));
    dz = longint'($signed(path_nodes[a].z)) - longint'($signed(path_nodes[b].z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic kept_t kept_node(input int idx, input logic sm, input logic last);
    kept_t k;
    k.x = path_nodes[idx].x;
    k.y = path_nodes[idx].y;
    k.z = path_nodes[idx].z;
    k.smoothed = sm;
    k.overflow = path_truncated;
    k.last = last;
    return k;
  endfunction

  // store one node; on the final node work out the simplified path
  function automatic void take_node(input gpns_pkg::node_t nd, input logic last,
                                    ref kept_t outs[$]);
    int n, i, j, best;
    longint lim;
    if (path_len < PATH_CAP) begin
      path_nodes[path_len] = nd;
      path_len++;
    end else begin
      path_truncated = 1'b1;
    end
    if (!last) return;
    n = path_len;
    lim = longint'(skip_reg) * longint'(skip_reg);
    if (n < gpns_pkg::MIN_SMOOTH) begin
      for (i = 0; i < n; i++) outs = {outs, kept_node(i, 1'b0, i == n - 1)};
    end else begin
      outs = {outs, kept_node(0, 1'b0, 1'b0)};
      i = 0;
      while (i < n - 1) begin
        best = i + 1;
        for (j = i + 2; j < n && j <= i + int'(reach_reg); j++) begin
          if (sep2(i, j) < lim) best = j;
          else break;
        end
        outs = {outs, kept_node(best, 1'b1, best == n - 1)};
        i = best;
      end
    end
    path_len = 0;
    path_truncated = 1'b0;
  endfunction

  function automatic int pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  task automatic flag_mismatch(input string what, input logic [19:0] got,
                               input logic [19:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at kept node %0d: %s got %h exp %h", checked_total, what, got, want);
  endtask

  task automatic feed_node(input gpns_pkg::node_t nd, input logic last, input logic known,
                           input logic want_sm, input bit steady);
    kept_t outs[$];
    int g;
    node_ch.valid <= 1'b1;
    node_ch.pos_x <= nd.x;
    node_ch.pos_y <= nd.y;
    node_ch.pos_z <= nd.z;
    node_ch.last_in <= last;
    do @(posedge clk); while (!node_ch.ready);
    take_node(nd, last, outs);
    if (known && outs.size() > 0)
      outs[outs.size() - 1] = '{x: nd.x, y: nd.y, z: nd.z, smoothed: want_sm,
                                 overflow: 1'b0, last: 1'b1};
    kept_q = {kept_q, outs};
    nodes_sent++;
    if (last) paths_sent++;
    if (!steady && $urandom_range(0, 2) == 0) begin
      g = pause_len();
      node_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    node_ch.valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [gpns_pkg::SKIP_W-1:0] skip,
                            input logic [gpns_pkg::LA_W-1:0] reach);
    cfg_we <= 1'b1;
    cfg_index <= gpns_pkg::CFG_SKIP;
    cfg_data <= skip;
    @(posedge clk);
    cfg_index <= gpns_pkg::CFG_LA;
    cfg_data <= {12'($urandom), reach};
    @(posedge clk);
    cfg_we <= 1'b0;
    skip_reg = skip;
    reach_reg = reach;
  endtask

  task automatic feed_path(input int len);
    gpns_pkg::node_t cur, nd;
    int span, k;
    bit steady, noisy;
    steady = ($urandom_range(0, 3) == 0);
    noisy = ($urandom_range(0, 9) == 0);
    span = (skip_reg < 16) ? 64 : (int'(skip_reg) >> $urandom_range(0, 2));
    cur.x = gpns_pkg::coord_t'($urandom);
    cur.y = gpns_pkg::coord_t'($urandom);
    cur.z = gpns_pkg::coord_t'($urandom);
    for (k = 0; k < len; k++) begin
      if (k == 0) begin
        nd = cur;
      end else if (noisy && $urandom_range(0, 1) == 1) begin
        nd.x = gpns_pkg::coord_t'($urandom);
        nd.y = gpns_pkg::coord_t'($urandom);
        nd.z = gpns_pkg::coord_t'($urandom);
      end else begin
        nd.x = gpns_pkg::coord_t'(int'(cur.x) + int'($urandom_range(0, span)) - span / 2);
        nd.y = gpns_pkg::coord_t'(int'(cur.y) + int'($urandom_range(0, span)) - span / 2);
        nd.z = gpns_pkg::coord_t'(int'(cur.z) + int'($urandom_range(0, span)) - span / 2);
      end
      cur = nd;
      feed_node(nd, k == len - 1, 1'b0, 1'b0, steady);
    end
    if (len > PATH_CAP) truncated_paths++;
  endtask

  function automatic int path_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return $urandom_range(1, 2);
    if (p < 85) return $urandom_range(3, 12);
    if (p < 96) return $urandom_range(13, 40);
    return $urandom_range(60, 70);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    kept_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (kept_q.size() == 0) begin
        flag_mismatch("result with nothing pending", res_ch.out_x, '0);
      end else begin
        want = kept_q.pop_front();
        if (res_ch.out_x !== want.x) flag_mismatch("out_x", res_ch.out_x, want.x);
        if (res_ch.out_y !== want.y) flag_mismatch("out_y", res_ch.out_y, want.y);
        if (res_ch.out_z !== want.z) flag_mismatch("out_z", res_ch.out_z, want.z);
        if (res_ch.smoothed !== want.smoothed)
          flag_mismatch("smoothed", 20'(res_ch.smoothed), 20'(want.smoothed));
        if (res_ch.overflow !== want.overflow)
          flag_mismatch("overflow", 20'(res_ch.overflow), 20'(want.overflow));
        if (res_ch.last_out !== want.last)
          flag_mismatch("last_out", 20'(res_ch.last_out), 20'(want.last));
      end
      checked_total++;
    end
  end

  // receiver back-pressure
  initial begin
    int n, pick;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        n = HOLD_CYCLES;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          res_ch.ready <= 1'b0;
          n = pause_len();
        end else begin
          res_ch.ready <= 1'b1;
          n = (pick < 95) ? $urandom_range(0, 6) : $urandom_range(50, 200);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int phase, budget, len;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= gpns_pkg::CFG_SKIP;
    cfg_data <= '0;
    node_ch.valid <= 1'b0;
    node_ch.pos_x <= '0;
    node_ch.pos_y <= '0;
    node_ch.pos_z <= '0;
    node_ch.last_in <= 1'b0;
    skip_reg = gpns_pkg::SKIP_RST;
    reach_reg = gpns_pkg::LA_RST;
    path_len = 0;
    path_truncated = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    checked_total = 0;
    nodes_sent = 0;
    paths_sent = 0;
    truncated_paths = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_PROBES; r++)
      feed_node('{x: probes[r].x, y: probes[r].y, z: probes[r].z}, probes[r].last,
                probes[r].known, probes[r].want_sm, 1'b1);

    for (phase = 0; phase < NUM_SETTINGS; phase++) begin
      drain_results();
      if (phase >= 8) begin
        skip_plan[phase] = 16'($urandom_range(1, 65535));
        reach_plan[phase] = 4'($urandom_range(0, 15));
      end
      set_config(skip_plan[phase], reach_plan[phase]);
      if (phase == 1) hold_req = 1'b1;
      budget = 0;
      if (phase == 0) feed_path(PATH_CAP + 1);
      while (budget < PHASE_NODES) begin
        len = path_length();
        feed_path(len);
        budget += len;
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end
    drain_results();
    repeat (40) @(posedge clk);

    $display("%0d nodes in %0d paths (%0d over capacity) across %0d register settings",
             nodes_sent, paths_sent, truncated_paths, NUM_SETTINGS + 1);
    $display("%0d kept nodes compared, %0d mismatches", checked_total, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
